/* hdl/ffcc_pkg.sv */
// ffcc_pkg: shared types and constants for the fixed frame checksum checker
// no dependencies

package ffcc_pkg;

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned NCHK     = 4;

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [2:0]       ekind_t;

  localparam pos_t  FRAME_LEN   = 5'd19;
  localparam pos_t  COUNTER_POS = 5'd17;
  localparam pos_t  CHECK_POS   = 5'd18;
  localparam pos_t  POS_MAX     = 5'd31;
  localparam byte_t HEAD0       = 8'hEB;
  localparam byte_t HEAD1       = 8'h90;
  localparam logic [8:0] SUM_MOD = 9'd255;
  localparam cnt_t  CNT_MAX     = {CNT_W{1'b1}};

  // check indexes
  localparam logic [1:0] CHK_LEN  = 2'd0;
  localparam logic [1:0] CHK_CNT  = 2'd1;
  localparam logic [1:0] CHK_HEAD = 2'd2;
  localparam logic [1:0] CHK_SUM  = 2'd3;

  // reported error kinds
  localparam ekind_t ERR_NONE = 3'd0;
  localparam ekind_t ERR_LEN  = 3'd1;
  localparam ekind_t ERR_CNT  = 3'd2;
  localparam ekind_t ERR_HEAD = 3'd3;
  localparam ekind_t ERR_SUM  = 3'd4;

endpackage

/* hdl/ffcc_if.sv */
// ffcc_in_if / ffcc_out_if: valid-ready channels of the frame checker
// depends on ffcc_pkg

interface ffcc_in_if;
  import ffcc_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_last;
  modport source(output valid, output data_byte, output frame_last, input ready);
  modport sink(input valid, input data_byte, input frame_last, output ready);
endinterface

interface ffcc_out_if;
  import ffcc_pkg::*;
  logic   valid;
  logic   ready;
  logic   frame_ok;
  ekind_t error_kind;
  cnt_t   consecutive_failures;
  cnt_t   total_failures;
  modport source(output valid, output frame_ok, output error_kind,
                 output consecutive_failures, output total_failures, input ready);
  modport sink(input valid, input frame_ok, input error_kind,
               input consecutive_failures, input total_failures, output ready);
endinterface

/* hdl/fixed_frame_checksum_checker_core.sv */
// fixed_frame_checksum_checker_core: checks 19-byte frames, one verdict per frame
// depends on ffcc_pkg and ffcc_if
// the verdict is valid in the cycle after the last-byte beat is accepted
// throughput: one byte per cycle unless stalled; running sum, per-check counters
//   update in the same cycle the byte is taken, result held in one output register
// reset: rst_n synchronous active low clears frame state, all failure counters,
//   the stored frame counter and the output valid

module fixed_frame_checksum_checker_core (
  input  logic              clk,
  input  logic              rst_n,
  ffcc_in_if.sink           in_bus,
  ffcc_out_if.source        out_bus
);
  import ffcc_pkg::*;

  pos_t  pos_r,  pos_nxt;
  byte_t sum_r,  sum_nxt;
  logic  hdr_r,  hdr_nxt;
  byte_t cap_r,  cap_nxt;
  byte_t prev_r, prev_nxt;
  cnt_t  cons_r [NCHK];
  cnt_t  cons_nxt [NCHK];
  cnt_t  tot_r [NCHK];
  cnt_t  tot_nxt [NCHK];

  logic   out_valid_r;
  logic   ok_r,   ok_nxt;
  ekind_t kind_r, kind_nxt;
  cnt_t   oc_r,   oc_nxt;
  cnt_t   ot_r,   ot_nxt;

  logic       take, fin;
  logic [8:0] sum_wide;
  logic       hdr_cur;
  logic [NCHK-1:0] bad, fail, pass;
  logic [1:0] fidx;
  logic       any_fail;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign take = in_bus.valid && in_bus.ready;
  assign fin  = take && in_bus.frame_last;

  always_comb begin
    hdr_cur = hdr_r;
    if (pos_r == 5'd0 && in_bus.data_byte != HEAD0) hdr_cur = 1'b0;
    if (pos_r == 5'd1 && in_bus.data_byte != HEAD1) hdr_cur = 1'b0;
    sum_wide = {1'b0, sum_r} + {1'b0, in_bus.data_byte};
    if (sum_wide >= SUM_MOD) sum_wide = sum_wide - SUM_MOD;

    bad[CHK_LEN]  = (pos_r != CHECK_POS);
    bad[CHK_CNT]  = (cap_r == prev_r);
    bad[CHK_HEAD] = !hdr_cur;
    bad[CHK_SUM]  = (in_bus.data_byte != sum_r);

    // first failing check wins, later checks count neither as pass nor fail
    fail = '0;
    pass = '0;
    if (bad[CHK_LEN]) begin
      fail[CHK_LEN] = 1'b1;
    end else begin
      pass[CHK_LEN] = 1'b1;
      if (bad[CHK_CNT]) begin
        fail[CHK_CNT] = 1'b1;
      end else begin
        pass[CHK_CNT] = 1'b1;
        if (bad[CHK_HEAD]) begin
          fail[CHK_HEAD] = 1'b1;
        end else begin
          pass[CHK_HEAD] = 1'b1;
          if (bad[CHK_SUM]) fail[CHK_SUM] = 1'b1;
          else              pass[CHK_SUM] = 1'b1;
        end
      end
    end
    any_fail = |fail;
    if (fail[CHK_LEN])       fidx = CHK_LEN;
    else if (fail[CHK_CNT])  fidx = CHK_CNT;
    else if (fail[CHK_HEAD]) fidx = CHK_HEAD;
    else                     fidx = CHK_SUM;
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    hdr_nxt  = hdr_r;
    cap_nxt  = cap_r;
    prev_nxt = prev_r;
    for (int i = 0; i < NCHK; i++) begin
      cons_nxt[i] = cons_r[i];
      tot_nxt[i]  = tot_r[i];
    end
    if (take) begin
      hdr_nxt = hdr_cur;
      if (pos_r == COUNTER_POS) cap_nxt = in_bus.data_byte;
      if (pos_r < CHECK_POS)    sum_nxt = sum_wide[7:0];
      if (pos_r < POS_MAX)      pos_nxt = pos_r + 5'd1;
      if (in_bus.frame_last) begin
        pos_nxt = '0;
        sum_nxt = '0;
        hdr_nxt = 1'b1;
        if (pass[CHK_CNT]) prev_nxt = cap_r;
        for (int i = 0; i < NCHK; i++) begin
          if (fail[i]) begin
            if (cons_r[i] != CNT_MAX) cons_nxt[i] = cons_r[i] + 1'b1;
            if (tot_r[i] != CNT_MAX)  tot_nxt[i]  = tot_r[i] + 1'b1;
          end else if (pass[i]) begin
            cons_nxt[i] = '0;
          end
        end
      end
    end
  end

  always_comb begin
    ok_nxt   = ok_r;
    kind_nxt = kind_r;
    oc_nxt   = oc_r;
    ot_nxt   = ot_r;
    if (fin) begin
      ok_nxt = !any_fail;
      if (any_fail) begin
        unique case (fidx)
          CHK_LEN:  kind_nxt = ERR_LEN;
          CHK_CNT:  kind_nxt = ERR_CNT;
          CHK_HEAD: kind_nxt = ERR_HEAD;
          CHK_SUM:  kind_nxt = ERR_SUM;
        endcase
        oc_nxt   = cons_nxt[fidx];
        ot_nxt   = tot_nxt[fidx];
      end else begin
        kind_nxt = ERR_NONE;
        oc_nxt   = '0;
        ot_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      hdr_r       <= 1'b1;
      cap_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCHK; i++) begin
        cons_r[i] <= '0;
        tot_r[i]  <= '0;
      end
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      hdr_r  <= hdr_nxt;
      cap_r  <= cap_nxt;
      prev_r <= prev_nxt;
      for (int i = 0; i < NCHK; i++) begin
        cons_r[i] <= cons_nxt[i];
        tot_r[i]  <= tot_nxt[i];
      end
      if (fin)                out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    kind_r <= kind_nxt;
    oc_r   <= oc_nxt;
    ot_r   <= ot_nxt;
  end

  assign out_bus.valid                = out_valid_r;
  assign out_bus.frame_ok             = ok_r;
  assign out_bus.error_kind           = kind_r;
  assign out_bus.consecutive_failures = oc_r;
  assign out_bus.total_failures       = ot_r;

endmodule
